// File: hdl/pruned_path_convolutional_decoder_defines.svh
// assertion macros shared by the decoder modules
// expects clk_i and rst_ni in the scope of each use
`ifndef PRUNED_PATH_CONVOLUTIONAL_DECODER_DEFINES_SVH
`define PRUNED_PATH_CONVOLUTIONAL_DECODER_DEFINES_SVH

// same-cycle implication
`define PPCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ppcd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and branch metric function of the path decoder
// used by the front, queue, back and top level; no dependencies
package ppcd_pkg;

  localparam int MaxMemory  = 4;
  localparam int MaxLen     = 64;
  localparam int MaxOutputs = 4;
  localparam int RegW       = MaxMemory + 1;
  localparam int StW        = MaxMemory;
  localparam int MetW       = 10;
  localparam int PathCap    = 8 << MaxMemory;
  localparam int PathIdxW   = $clog2(PathCap);
  localparam int SurvW      = PathIdxW - 1;
  localparam int StepW      = $clog2(MaxLen);
  localparam int LenW       = StepW + 1;
  localparam int SymW       = MaxOutputs;
  localparam int EntW       = StW + MetW;
  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);

  localparam logic [MetW-1:0] MetricMax = '1;

  typedef enum logic [2:0] {
    CfgPolyA   = 3'd0,
    CfgPolyB   = 3'd1,
    CfgPolyC   = 3'd2,
    CfgPolyD   = 3'd3,
    CfgOutputs = 3'd4,
    CfgMemory  = 3'd5
  } cfg_idx_e;

  // clamped configuration as seen by the datapath
  typedef struct packed {
    logic [MaxOutputs-1:0][RegW-1:0] poly;
    logic [2:0]                      n;
    logic [2:0]                      k;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            last;
    logic            drop;
  } op_t;

  // hamming distance between a symbol and the coded bits of register u
  function automatic logic [2:0] branch_dist(input logic [MaxOutputs-1:0][RegW-1:0] poly,
                                             input logic [2:0] n,
                                             input logic [SymW-1:0] sym,
                                             input logic [RegW-1:0] u);
    logic [2:0] d;
    logic [2:0] pos;
    logic       cb;
    d = '0;
    for (int x = 0; x < MaxOutputs; x++) begin
      pos = n - 3'(x) - 3'd1;
      cb  = ^(poly[x] & u);
      if (3'(x) < n) begin
        d = d + {2'b00, cb ^ sym[pos[1:0]]};
      end
    end
    return d;
  endfunction

endpackage

// File: hdl/pruned_path_convolutional_decoder.sv
`timescale 1ns / 1ps
// Hard-decision decoder for a rate 1/n convolutional code with a pruned path list.
// Input channel s_axis: one received symbol per item, tlast on the final symbol of
// a message. Output channel m_axis: after the final symbol, one decoded bit per
// item in message order, tlast on the final bit, tuser set when symbols past 64
// were dropped. Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0..3 polynomials, 4 outputs per bit, 5 memory order); write only when idle.
// Per symbol the back end makes one copy pass over the list (one path a cycle),
// then an extend pass that writes both branches of each of its L paths, L up to 64.
// When the list exceeds four times the state count, ten
// median passes over the list (L up to 128) come first.
// The final symbol adds a minimum search over up to 128 paths and a traceback
// that reads the map once per symbol, then one bit a cycle as the receiver takes them.
// A two-entry queue lets the input side keep accepting while the back end works.
// Reset restores the register defaults and an empty message with the zero path;
// no memory clearing pass is needed. A stalled receiver only holds the back end.
module pruned_path_convolutional_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i,
  input  logic [7:0] s_axis_tdata,   // [3:0] received_symbol, [7:4] zero
  input  logic       s_axis_tlast,   // last_symbol
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] decoded_bit, [7:1] zero
  output logic       m_axis_tlast,   // last_bit
  output logic       m_axis_tuser,   // overflow
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready
);

  logic [ppcd_pkg::MaxOutputs-1:0][ppcd_pkg::RegW-1:0] poly_q;
  logic [2:0]     opb_q, mo_q;
  ppcd_pkg::cfg_t cfg;
  ppcd_pkg::op_t  f_op, q_op;
  logic           push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q[0] <= 5'd13;
      poly_q[1] <= 5'd15;
      poly_q[2] <= 5'd11;
      poly_q[3] <= 5'd0;
      opb_q     <= 3'd3;
      mo_q      <= 3'd3;
    end else if (cfg_we_i) begin
      case (ppcd_pkg::cfg_idx_e'(cfg_idx_i))
        ppcd_pkg::CfgPolyA:   poly_q[0] <= cfg_data_i;
        ppcd_pkg::CfgPolyB:   poly_q[1] <= cfg_data_i;
        ppcd_pkg::CfgPolyC:   poly_q[2] <= cfg_data_i;
        ppcd_pkg::CfgPolyD:   poly_q[3] <= cfg_data_i;
        ppcd_pkg::CfgOutputs: opb_q     <= cfg_data_i[2:0];
        ppcd_pkg::CfgMemory:  mo_q      <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // out-of-range counts clamp to the supported range
  always_comb begin
    cfg.poly = poly_q;
    if (opb_q == 3'd0) begin
      cfg.n = 3'd1;
    end else if (opb_q inside {[3'd5:3'd7]}) begin
      cfg.n = 3'(ppcd_pkg::MaxOutputs);
    end else begin
      cfg.n = opb_q;
    end
    if (mo_q == 3'd0) begin
      cfg.k = 3'd1;
    end else if (mo_q inside {[3'd5:3'd7]}) begin
      cfg.k = 3'(ppcd_pkg::MaxMemory);
    end else begin
      cfg.k = mo_q;
    end
  end

  ppcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_i           (cfg.n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .full_i        (full),
    .push_o        (push),
    .op_o          (f_op)
  );

  ppcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (f_op),
    .pop_i   (pop),
    .op_o    (q_op),
    .full_o  (full),
    .empty_o (empty)
  );

  ppcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .empty_i       (empty),
    .op_i          (q_op),
    .pop_o         (pop),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

endmodule

// File: hdl/ppcd_front.sv
`timescale 1ns / 1ps
// input side: accepts symbols, masks unused bits, marks dropped items
// depends on ppcd_pkg
module ppcd_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [2:0]              n_i,
  input  logic [7:0]              s_axis_tdata,   // [3:0] received_symbol, [7:4] zero
  input  logic                    s_axis_tlast,   // last_symbol
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic                    full_i,
  output logic                    push_o,
  output ppcd_pkg::op_t           op_o
);

  logic [ppcd_pkg::LenW-1:0] cnt_q, cnt_d;
  logic [ppcd_pkg::SymW-1:0] mask;
  logic                      acc;

  assign s_axis_tready = !full_i;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign push_o        = acc;
  assign mask          = ppcd_pkg::SymW'((5'd1 << n_i) - 5'd1);

  always_comb begin
    op_o.sym  = s_axis_tdata[ppcd_pkg::SymW-1:0] & mask;
    op_o.last = s_axis_tlast;
    op_o.drop = (cnt_q == ppcd_pkg::LenW'(ppcd_pkg::MaxLen));
    cnt_d     = cnt_q;
    if (acc) begin
      if (s_axis_tlast) begin
        cnt_d = '0;
      end else if (!op_o.drop) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hdl/ppcd_queue.sv
`timescale 1ns / 1ps
// two-entry item queue between the front and the back
// depends on ppcd_pkg and the assertion macro header
`include "pruned_path_convolutional_decoder_defines.svh"
module ppcd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ppcd_pkg::op_t op_i,
  input  logic          pop_i,
  output ppcd_pkg::op_t op_o,
  output logic          full_o,
  output logic          empty_o
);

  ppcd_pkg::op_t              mem_q [ppcd_pkg::QDepth];
  logic [ppcd_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [ppcd_pkg::QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (ppcd_pkg::QPtrW+1)'(ppcd_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign op_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `PPCD_ASSERT_IMP(a_no_overrun, push_i, !full_o, "push into full queue")
  `PPCD_ASSERT_IMP(a_no_underrun, pop_i, !empty_o, "pop from empty queue")
  `PPCD_ASSERT_NXT(a_fill_seen, push_i && !pop_i, !empty_o, "pushed item lost")

endmodule

// File: hdl/ppcd_back.sv
`timescale 1ns / 1ps
// path engine: median pruning, two-way extension, traceback and result output
// depends on ppcd_pkg and the assertion macro header
`include "pruned_path_convolutional_decoder_defines.svh"
module ppcd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppcd_pkg::cfg_t cfg_i,
  input  logic           empty_i,
  input  ppcd_pkg::op_t  op_i,
  output logic           pop_o,
  output logic [7:0]     m_axis_tdata,   // [0] decoded_bit, [7:1] zero
  output logic           m_axis_tlast,   // last_bit
  output logic           m_axis_tuser,   // overflow
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MED  = 4'd1;
  localparam logic [3:0] ST_CPY  = 4'd2;
  localparam logic [3:0] ST_EXT  = 4'd3;
  localparam logic [3:0] ST_FIN  = 4'd4;
  localparam logic [3:0] ST_MIN  = 4'd5;
  localparam logic [3:0] ST_TBR  = 4'd6;
  localparam logic [3:0] ST_TBW  = 4'd7;
  localparam logic [3:0] ST_EMIT = 4'd8;

  localparam int IW = ppcd_pkg::PathIdxW;
  localparam int CW = ppcd_pkg::PathIdxW + 1;
  localparam int MW = ppcd_pkg::MetW;

  // path banks (ping-pong) and traceback map
  logic [ppcd_pkg::EntW-1:0] bank0 [ppcd_pkg::PathCap];
  logic [ppcd_pkg::EntW-1:0] bank1 [ppcd_pkg::PathCap];
  logic [IW-1:0]             tmap [ppcd_pkg::MaxLen * ppcd_pkg::PathCap / 2];
  logic [ppcd_pkg::EntW-1:0] rd0_q, rd1_q;
  logic [IW-1:0]             map_rd_q;

  logic [3:0]                st_q, st_d;
  logic                      cur_q, cur_d, fresh_q, fresh_d, dropped_q, dropped_d;
  logic [CW-1:0]             live_q, live_d, lim_q, lim_d, iss_q, iss_d;
  logic [CW-1:0]             cle_q, cle_d, kept_q, kept_d, curc_q, curc_d;
  logic [ppcd_pkg::LenW-1:0] step_q, step_d, ecnt_q, ecnt_d;
  ppcd_pkg::op_t             op_q, op_d;
  logic [MW-1:0]             med_q, med_d, bestm_q, bestm_d;
  logic [3:0]                bit_q, bit_d;
  logic                      rv_q, rv_d, pen_q, pen_d;
  logic [IW-1:0]             ri_q, ri_d, best_q, best_d, p_q, p_d;
  logic [1:0]                ph_q, ph_d;
  logic [ppcd_pkg::EntW-1:0] hold_q, hold_d;
  logic [ppcd_pkg::SurvW-1:0] hidx_q, hidx_d;
  logic [ppcd_pkg::StepW-1:0] tbt_q, tbt_d;
  logic [ppcd_pkg::MaxLen-1:0] hist_q, hist_d;
  logic                      ov_q, ov_d, od_q, od_d, ol_q, ol_d, oo_q, oo_d;

  logic [IW-1:0]             ra;
  logic                      bw_en, mw_en;
  logic [IW-1:0]             bw_addr;
  logic [ppcd_pkg::EntW-1:0] bw_data, ent, src;
  logic [ppcd_pkg::StepW+ppcd_pkg::SurvW-1:0] mw_addr, mr_addr;
  logic [IW-1:0]             mw_data;
  logic [ppcd_pkg::StW-1:0]  smask, mstate, nstate;
  logic [MW-1:0]             mmet, cand, nmet;
  logic [CW-1:0]             lim_now, target;
  logic                      pass_done, br_b, slot_free;
  logic [ppcd_pkg::RegW-1:0] u;
  logic [MW:0]               msum;

  assign ent    = fresh_q ? '0 : (cur_q ? rd1_q : rd0_q);
  assign mstate = ent[ppcd_pkg::EntW-1:MW];
  assign mmet   = ent[MW-1:0];
  assign smask  = ppcd_pkg::StW'((5'd1 << cfg_i.k) - 5'd1);
  assign lim_now = CW'(8'd4 << cfg_i.k);
  assign target  = {1'b0, live_q[CW-1:1]} + 1'b1;
  assign cand    = med_q | MW'((11'd1 << bit_q) - 11'd1);
  assign pass_done = (iss_q >= live_q) && !rv_q;
  assign slot_free = !ov_q || m_axis_tready;

  // branch of the extension step: phase 1 from memory, phase 2 from hold
  assign src  = (ph_q == 2'd1) ? ent : hold_q;
  assign br_b = (ph_q == 2'd2);
  assign u    = {1'b0, src[ppcd_pkg::EntW-1:MW] & smask}
              | (ppcd_pkg::RegW'(br_b) << cfg_i.k);
  assign nstate = u[ppcd_pkg::RegW-1:1];
  assign msum   = {1'b0, src[MW-1:0]}
                + (MW+1)'(ppcd_pkg::branch_dist(cfg_i.poly, cfg_i.n, op_q.sym, u));
  assign nmet   = msum[MW] ? ppcd_pkg::MetricMax : msum[MW-1:0];

  always_comb begin
    st_d = st_q; cur_d = cur_q; fresh_d = fresh_q; dropped_d = dropped_q;
    live_d = live_q; lim_d = lim_q; iss_d = iss_q; cle_d = cle_q;
    kept_d = kept_q; curc_d = curc_q; step_d = step_q; ecnt_d = ecnt_q;
    op_d = op_q; med_d = med_q; bestm_d = bestm_q; bit_d = bit_q;
    rv_d = 1'b0; pen_d = pen_q; ri_d = ri_q; best_d = best_q; p_d = p_q;
    ph_d = ph_q; hold_d = hold_q; hidx_d = hidx_q; tbt_d = tbt_q; hist_d = hist_q;
    ov_d = ov_q; od_d = od_q; ol_d = ol_q; oo_d = oo_q;
    pop_o = 1'b0; ra = iss_q[IW-1:0];
    bw_en = 1'b0; bw_addr = '0; bw_data = ent;
    mw_en = 1'b0; mw_addr = {step_q[ppcd_pkg::StepW-1:0], kept_q[ppcd_pkg::SurvW-1:0]};
    mw_data = ri_q; mr_addr = {tbt_q, p_q[IW-1:1]};

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    // shared read issue for the single-read passes
    if ((st_q == ST_MED) || (st_q == ST_CPY) || (st_q == ST_MIN)) begin
      if (iss_q < live_q) begin
        rv_d  = 1'b1;
        ri_d  = iss_q[IW-1:0];
        iss_d = iss_q + 1'b1;
      end
    end

    case (st_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          op_d  = op_i;
          iss_d = '0;
          if (op_i.drop) begin
            dropped_d = 1'b1;
            if (op_i.last) begin
              st_d = ST_FIN;
            end
          end else begin
            lim_d = lim_now;
            if (live_q > lim_now) begin
              pen_d = 1'b1;
              med_d = '0;
              bit_d = 4'(MW - 1);
              cle_d = '0;
              st_d  = ST_MED;
            end else begin
              pen_d  = 1'b0;
              kept_d = '0;
              curc_d = live_q;
              st_d   = ST_CPY;
            end
          end
        end
      end
      ST_MED: begin
        if (rv_q && (mmet <= cand)) begin
          cle_d = cle_q + 1'b1;
        end
        if (pass_done) begin
          // bit of the median: stays 0 when enough metrics are at or below
          if (cle_q < target) begin
            med_d = med_q | (MW'(1) << bit_q);
          end
          cle_d = '0;
          iss_d = '0;
          if (bit_q == 4'd0) begin
            kept_d = '0;
            curc_d = live_q;
            st_d   = ST_CPY;
          end else begin
            bit_d = bit_q - 1'b1;
          end
        end
      end
      ST_CPY: begin
        if (rv_q) begin
          if (pen_q && (curc_q > lim_q) && (mmet >= med_q)) begin
            curc_d = curc_q - 1'b1;
          end else begin
            bw_en   = 1'b1;
            bw_addr = kept_q[IW-1:0];
            mw_en   = (kept_q < CW'(ppcd_pkg::PathCap / 2));
            kept_d  = kept_q + 1'b1;
          end
        end
        if (pass_done) begin
          live_d  = (kept_q > lim_q) ? lim_q : kept_q;
          cur_d   = !cur_q;
          fresh_d = 1'b0;
          iss_d   = '0;
          ph_d    = 2'd0;
          st_d    = ST_EXT;
        end
      end
      ST_EXT: begin
        bw_data = {nstate, nmet};
        bw_addr = {hidx_q, br_b};
        case (ph_q)
          2'd0: begin
            hidx_d = iss_q[ppcd_pkg::SurvW-1:0];
            iss_d  = iss_q + 1'b1;
            ph_d   = 2'd1;
          end
          2'd1: begin
            bw_en  = 1'b1;
            hold_d = ent;
            ph_d   = 2'd2;
          end
          default: begin
            bw_en = 1'b1;
            if (iss_q < live_q) begin
              hidx_d = iss_q[ppcd_pkg::SurvW-1:0];
              iss_d  = iss_q + 1'b1;
              ph_d   = 2'd1;
            end else begin
              live_d = live_q << 1;
              cur_d  = !cur_q;
              step_d = step_q + 1'b1;
              ph_d   = 2'd0;
              st_d   = op_q.last ? ST_FIN : ST_IDLE;
            end
          end
        endcase
      end
      ST_FIN: begin
        iss_d = '0;
        if (step_q == '0) begin
          live_d = CW'(1); fresh_d = 1'b1; step_d = '0; dropped_d = 1'b0;
          st_d = ST_IDLE;
        end else begin
          st_d = ST_MIN;
        end
      end
      ST_MIN: begin
        // first minimum wins: strict compare
        if (rv_q && ((ri_q == '0) || (mmet < bestm_q))) begin
          best_d  = ri_q;
          bestm_d = mmet;
        end
        if (pass_done) begin
          p_d    = best_q;
          tbt_d  = ppcd_pkg::StepW'(step_q - 1'b1);
          ecnt_d = step_q;
          st_d   = ST_TBR;
        end
      end
      ST_TBR: begin
        hist_d = {hist_q[ppcd_pkg::MaxLen-2:0], p_q[0]};
        st_d   = (tbt_q == '0) ? ST_EMIT : ST_TBW;
      end
      ST_TBW: begin
        p_d   = map_rd_q;
        tbt_d = tbt_q - 1'b1;
        st_d  = ST_TBR;
      end
      ST_EMIT: begin
        if (slot_free) begin
          ov_d   = 1'b1;
          od_d   = hist_q[0];
          ol_d   = (ecnt_q == ppcd_pkg::LenW'(1));
          oo_d   = dropped_q;
          hist_d = hist_q >> 1;
          ecnt_d = ecnt_q - 1'b1;
          if (ecnt_q == ppcd_pkg::LenW'(1)) begin
            live_d = CW'(1); fresh_d = 1'b1; step_d = '0; dropped_d = 1'b0;
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bw_en && cur_q) begin
      bank0[bw_addr] <= bw_data;
    end
    rd0_q <= bank0[ra];
  end

  always_ff @(posedge clk_i) begin
    if (bw_en && !cur_q) begin
      bank1[bw_addr] <= bw_data;
    end
    rd1_q <= bank1[ra];
  end

  always_ff @(posedge clk_i) begin
    if (mw_en) begin
      tmap[mw_addr] <= mw_data;
    end
    map_rd_q <= tmap[mr_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cur_q <= 1'b0; fresh_q <= 1'b1; dropped_q <= 1'b0;
      live_q <= CW'(1); step_q <= '0; rv_q <= 1'b0; ph_q <= 2'd0;
      ov_q <= 1'b0; iss_q <= '0;
    end else begin
      st_q <= st_d; cur_q <= cur_d; fresh_q <= fresh_d; dropped_q <= dropped_d;
      live_q <= live_d; step_q <= step_d; rv_q <= rv_d; ph_q <= ph_d;
      ov_q <= ov_d; iss_q <= iss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= lim_d; cle_q <= cle_d; kept_q <= kept_d; curc_q <= curc_d;
    ecnt_q <= ecnt_d; op_q <= op_d; med_q <= med_d; bestm_q <= bestm_d;
    bit_q <= bit_d; pen_q <= pen_d; ri_q <= ri_d; best_q <= best_d; p_q <= p_d;
    hold_q <= hold_d; hidx_q <= hidx_d; tbt_q <= tbt_d; hist_q <= hist_d;
    od_q <= od_d; ol_q <= ol_d; oo_q <= oo_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'b0, od_q};
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = oo_q;

  `PPCD_ASSERT_IMP(a_fresh_single, fresh_q, live_q == CW'(1), "fresh list not single path")
  `PPCD_ASSERT_IMP(a_ext_fits, st_q == ST_EXT, live_q <= CW'(ppcd_pkg::PathCap / 2), "extend overfills bank")
  `PPCD_ASSERT_IMP(a_emit_count, st_q == ST_EMIT, (ecnt_q != '0) && (ecnt_q <= step_q), "emit count out of step")

endmodule
